>>> rtl/mlr_pkg.sv
// mlr_pkg: shared constants, codes and record types of the multichannel level ramp unit
// no dependencies; imported by mlr_step and multichannel_level_ramp_unit
`timescale 1ns / 1ps

package mlr_pkg;

    localparam int CHANNELS   = 4;
    localparam int LEVEL_BITS = 16;
    localparam int CH_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    typedef enum logic [2:0] {
        FN_TICK   = 3'd0,
        FN_RAMP   = 3'd1,
        FN_SET    = 3'd2,
        FN_ENABLE = 3'd3,
        FN_QUERY  = 3'd4
    } func_t;

    localparam logic KIND_LEVEL  = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMD,
        S_TICK,
        S_FLUSH
    } state_t;

    typedef struct packed {
        logic [LEVEL_BITS-1:0] cur;
        logic [LEVEL_BITS-1:0] tgt;
        logic [7:0]            stp;
        logic [7:0]            per;
        logic [7:0]            cnt;
        logic                  en;
        logic                  mov;
    } chan_rec_t;

    typedef struct packed {
        logic        kind;
        logic [3:0]  chan;
        logic [15:0] level;
        logic        moving;
        logic        last;
    } result_t;

endpackage

>>> rtl/multichannel_level_ramp_unit.sv
// multichannel_level_ramp_unit: top level, channel record memory, command sequencer
// depends on mlr_pkg and mlr_step
`timescale 1ns / 1ps
//
// Use: requests enter on the s_ stream; tuser carries the function code, tdata the
// channel, level, period, step and enable. Results leave on the m_ stream; tuser is
// the kind (level update or status reply), tlast marks the last result of a request.
// Per-channel state sits in one record memory with a registered read port; the
// sequencer reads a record, updates it and writes it back.
// A command is accepted, then its record is read, modified and written back; a tick
// is accepted, walks every channel record in turn, then flushes the last result.
// s_tready is high only while the sequencer is idle, one request at a time.
// Order: a query reply enters the output register from S_CMD once it is free; tick
// results lag their channel by one record since each is held until the next stepped
// channel or the end of the walk decides its tlast.
// Reset: aresetn low clears the sequencer, the output valid flag and the per-entry valid
// bits, so every channel reads as all zero until written.
// Stall: a result waits in the output register; the sequencer holds its place when a
// further result has nowhere to go and resumes once m_tready takes the waiting one.

module multichannel_level_ramp_unit
    import mlr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // channel[3:0], level[19:4], period[27:20], step[35:28], enable[36], zero[39:37]
    input  logic [39:0] s_tdata,
    // func[2:0]
    input  logic [2:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // chan_out[3:0], level_out[19:4], moving[20], zero[23:21]
    output logic [23:0] m_tdata,
    // kind[0]
    output logic        m_tuser,
    output logic        m_tlast
);

    state_t state_reg, state_next;

    chan_rec_t mem [CHANNELS];
    chan_rec_t rd_data_reg;
    logic      rd_valid_reg;
    logic [CHANNELS-1:0] ent_valid_reg;

    logic [2:0]            cmd_func_reg;
    logic [CH_W-1:0]       cmd_ch_reg;
    logic [3:0]            cmd_chan_reg;
    logic                  cmd_ch_valid_reg;
    logic [LEVEL_BITS-1:0] cmd_level_reg;
    logic [7:0]            cmd_per_reg;
    logic [7:0]            cmd_stp_reg;
    logic                  cmd_en_reg;

    logic [CH_W-1:0] idx_reg, idx_next;
    result_t         held_reg, held_next;
    logic            held_valid_reg, held_valid_next;
    result_t         out_reg;
    logic            out_valid_reg;

    logic            accept;
    logic            s_ch_valid;
    logic            slot_free;
    logic            idx_last;
    chan_rec_t       rec;
    chan_rec_t       tick_rec;
    logic            tick_stepped;
    logic            tick_stall;
    logic            cmd_stall;
    logic            mem_we;
    logic [CH_W-1:0] mem_waddr;
    chan_rec_t       mem_wdata;
    logic [CH_W-1:0] rd_addr;
    logic            push;
    result_t         push_data;

    assign accept     = s_tvalid && s_tready;
    assign s_tready   = (state_reg == S_IDLE);
    assign s_ch_valid = {1'b0, s_tdata[3:0]} < 5'(CHANNELS);
    assign slot_free  = !out_valid_reg || m_tready;
    assign idx_last   = (idx_reg == CH_W'(CHANNELS - 1));
    assign rec        = rd_valid_reg ? rd_data_reg : '0;
    assign tick_stall = tick_stepped && held_valid_reg && !slot_free;
    assign cmd_stall  = (cmd_func_reg == FN_QUERY) && !slot_free;

    mlr_step u_step (
        .rec_i     (rec),
        .rec_o     (tick_rec),
        .stepped_o (tick_stepped)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    if (s_tuser == FN_TICK) begin
                        state_next = S_TICK;
                    end else if (s_tuser >= FN_RAMP && s_tuser <= FN_QUERY) begin
                        state_next = S_CMD;
                    end
                end
            end
            S_CMD: begin
                if (!cmd_stall) begin
                    state_next = S_IDLE;
                end
            end
            S_TICK: begin
                if (!tick_stall && idx_last) begin
                    state_next = S_FLUSH;
                end
            end
            S_FLUSH: begin
                if (!held_valid_reg || slot_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // datapath control
    always_comb begin
        mem_we          = 1'b0;
        mem_waddr       = cmd_ch_reg;
        mem_wdata       = rec;
        rd_addr         = '0;
        push            = 1'b0;
        push_data       = held_reg;
        idx_next        = idx_reg;
        held_next       = held_reg;
        held_valid_next = held_valid_reg;
        unique case (state_reg)
            S_IDLE: begin
                idx_next = '0;
                if (s_tuser != FN_TICK && s_ch_valid) begin
                    rd_addr = s_tdata[CH_W-1:0];
                end
            end
            S_CMD: begin
                rd_addr = cmd_ch_reg;
                case (cmd_func_reg)
                    FN_RAMP: begin
                        if (cmd_ch_valid_reg && cmd_per_reg != 8'd0) begin
                            mem_we        = 1'b1;
                            mem_wdata.tgt = cmd_level_reg;
                            mem_wdata.per = cmd_per_reg;
                            mem_wdata.stp = cmd_stp_reg;
                            mem_wdata.mov = 1'b1;
                        end
                    end
                    FN_SET: begin
                        if (cmd_ch_valid_reg) begin
                            mem_we        = 1'b1;
                            mem_wdata.tgt = cmd_level_reg;
                            mem_wdata.cur = cmd_level_reg;
                            mem_wdata.en  = cmd_en_reg;
                            mem_wdata.cnt = 8'd0;
                        end
                    end
                    FN_ENABLE: begin
                        if (cmd_ch_valid_reg) begin
                            mem_we        = 1'b1;
                            mem_wdata.en  = cmd_en_reg;
                            mem_wdata.cnt = 8'd0;
                        end
                    end
                    FN_QUERY: begin
                        push             = slot_free;
                        push_data.kind   = KIND_STATUS;
                        push_data.chan   = cmd_chan_reg;
                        push_data.level  = cmd_ch_valid_reg ? 16'(rec.cur) : 16'd0;
                        push_data.moving = cmd_ch_valid_reg ? rec.mov : 1'b0;
                        push_data.last   = 1'b1;
                    end
                    default: ;
                endcase
            end
            S_TICK: begin
                rd_addr   = (tick_stall || idx_last) ? idx_reg : idx_reg + CH_W'(1);
                mem_waddr = idx_reg;
                mem_wdata = tick_rec;
                if (!tick_stall) begin
                    mem_we   = 1'b1;
                    idx_next = idx_reg + CH_W'(1);
                    if (tick_stepped) begin
                        push                  = held_valid_reg;
                        push_data.last        = 1'b0;
                        held_valid_next       = 1'b1;
                        held_next.kind        = KIND_LEVEL;
                        held_next.chan        = 4'(idx_reg);
                        held_next.level       = 16'(tick_rec.cur);
                        held_next.moving      = tick_rec.mov;
                        held_next.last        = 1'b0;
                    end
                end
            end
            S_FLUSH: begin
                if (held_valid_reg && slot_free) begin
                    push            = 1'b1;
                    push_data.last  = 1'b1;
                    held_valid_next = 1'b0;
                end
            end
            default: ;
        endcase
    end

    // record memory and valid bits
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ent_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
        end else begin
            rd_valid_reg <= ent_valid_reg[rd_addr];
            if (mem_we) begin
                ent_valid_reg[mem_waddr] <= 1'b1;
            end
        end
    end

    // request capture
    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_func_reg     <= s_tuser;
            cmd_ch_reg       <= s_ch_valid ? s_tdata[CH_W-1:0] : '0;
            cmd_chan_reg     <= s_tdata[3:0];
            cmd_ch_valid_reg <= s_ch_valid;
            cmd_level_reg    <= LEVEL_BITS'(s_tdata[19:4]);
            cmd_per_reg      <= s_tdata[27:20];
            cmd_stp_reg      <= s_tdata[35:28];
            cmd_en_reg       <= s_tdata[36];
        end
    end

    // sequencer and result registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            idx_reg        <= '0;
            held_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            held_valid_reg <= held_valid_next;
            if (push) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        held_reg <= held_next;
        if (push) begin
            out_reg <= push_data;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_reg.moving, out_reg.level, out_reg.chan};
    assign m_tuser  = out_reg.kind;
    assign m_tlast  = out_reg.last;

    // checks
    a_held_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_IDLE |-> !held_valid_reg)
        else $error("held tick result left over in idle");

    a_no_write_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> state_reg != S_IDLE)
        else $error("record write while idle");

    a_push_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (!out_valid_reg || m_tready))
        else $error("result pushed over a waiting one");

    a_query_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_tuser == FN_QUERY) |=> state_reg == S_CMD)
        else $error("query not sequenced");

    a_status_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == KIND_STATUS) |-> m_tlast)
        else $error("status reply without tlast");

endmodule

>>> rtl/mlr_step.sv
// mlr_step: tick update of one channel record (count, step toward target, clamp)
// depends on mlr_pkg
`timescale 1ns / 1ps

module mlr_step
    import mlr_pkg::*;
(
    input  chan_rec_t rec_i,
    output chan_rec_t rec_o,
    output logic      stepped_o
);

    logic [7:0]            cnt_inc;
    logic [LEVEL_BITS-1:0] stp_ext;
    logic [LEVEL_BITS-1:0] gap;
    logic                  down;

    assign cnt_inc = rec_i.cnt + 8'd1;
    assign stp_ext = LEVEL_BITS'(rec_i.stp);
    assign down    = rec_i.cur > rec_i.tgt;
    assign gap     = down ? (rec_i.cur - rec_i.tgt) : (rec_i.tgt - rec_i.cur);

    always_comb begin
        rec_o     = rec_i;
        stepped_o = 1'b0;
        if (rec_i.en && rec_i.mov) begin
            if (cnt_inc < rec_i.per) begin
                rec_o.cnt = cnt_inc;
            end else begin
                rec_o.cnt = 8'd0;
                stepped_o = 1'b1;
                if (gap <= stp_ext) begin
                    rec_o.cur = rec_i.tgt;
                    rec_o.mov = 1'b0;
                end else if (down) begin
                    rec_o.cur = rec_i.cur - stp_ext;
                end else begin
                    rec_o.cur = rec_i.cur + stp_ext;
                end
            end
        end
    end

endmodule
